[hw/rtl/mfls_pkg.sv]
// Shared sizes, entry layout and state codes for the per-channel frame statistics block.
// Used by the statistics core, its port checker and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package mfls_pkg;

    localparam int CHANNELS = 8;
    // The mean is taken by a right shift, so the frame length must be a power of two.
    localparam int SAMPLES  = 128;

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SMP_W    = $clog2(SAMPLES);
    localparam int SMP_LOG2 = $clog2(SAMPLES);
    localparam int SUM_W    = 16 + SMP_LOG2;
    localparam int ENTRY_W  = 32 + SUM_W;

    localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(CHANNELS - 1);
    localparam logic [SMP_W-1:0] LAST_SMP  = SMP_W'(SAMPLES - 1);
    localparam logic [2:0]       LAST_CH_FIELD = 3'(CHANNELS - 1);

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [15:0] minimum;
        logic signed [15:0] maximum;
        logic [SUM_W-1:0]   sum;
    } t_entry;

    localparam t_entry RESET_ENTRY = '{minimum: SAMPLE_MAX, maximum: SAMPLE_MIN, sum: '0};

    typedef enum logic [2:0] {
        ST_ACC  = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

endpackage

[hw/rtl/mfls_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used for the per-channel accumulator store.
`timescale 1ns / 1ps

module mfls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read data holds until the next read; a read of the entry being written returns old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/multichannel_frame_level_stats_core.sv]
// Results follow the last item of a frame through the input stage register, the RAM read
// issued in ST_READ and the output register loaded in ST_LOAD, then come one per cycle while
// the output is not stalled. Throughput: one item per cycle, but the input stalls
// from a frame's last item until its last result is loaded; the single read port of
// the accumulator RAM serves result read-out. Reset (synchronous, active low) empties the
// pipeline and marks every channel's accumulators as cleared; the RAM itself is not swept.
`timescale 1ns / 1ps

module multichannel_frame_level_stats_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_sample,
    output logic               o_stall,
    output logic               o_valid,
    output logic [2:0]         o_channel,
    output logic signed [15:0] o_minimum,
    output logic signed [15:0] o_maximum,
    output logic [15:0]        o_mean_magnitude,
    output logic               o_last,
    input  logic               i_stall
);

    mfls_pkg::t_state r_state, n_state;

    logic [mfls_pkg::CH_W-1:0]  r_ch_pos, n_ch_pos;
    logic [mfls_pkg::SMP_W-1:0] r_smp_pos, n_smp_pos;
    logic [mfls_pkg::CH_W-1:0]  r_emit_ch, n_emit_ch;
    logic [mfls_pkg::CHANNELS-1:0] r_entry_valid, n_entry_valid;

    logic                       r_s1_valid;
    logic signed [15:0]         r_s1_sample;
    logic [mfls_pkg::CH_W-1:0]  r_s1_ch;
    logic                       r_s1_frame_end;

    logic                       r_fwd_hit;
    mfls_pkg::t_entry           r_fwd_data;

    logic                       r_out_valid;
    logic [2:0]                 r_out_channel;
    logic signed [15:0]         r_out_minimum;
    logic signed [15:0]         r_out_maximum;
    logic [15:0]                r_out_mean;
    logic                       r_out_last;

    logic                       accept;
    logic                       out_free;
    logic                       load_out;
    logic                       rd_en;
    logic [mfls_pkg::CH_W-1:0]  rd_addr;
    logic [mfls_pkg::ENTRY_W-1:0] rd_data;
    logic                       wr_en;
    mfls_pkg::t_entry           old_entry;
    mfls_pkg::t_entry           new_entry;
    mfls_pkg::t_entry           emit_entry;
    logic [16:0]                magnitude;

    assign o_stall  = (r_state != mfls_pkg::ST_ACC) || (r_s1_valid && r_s1_frame_end);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign wr_en    = r_s1_valid;

    mfls_ram #(
        .WIDTH(mfls_pkg::ENTRY_W),
        .DEPTH(mfls_pkg::CHANNELS)
    ) u_acc_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_s1_ch),
        .i_wr_data(new_entry),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // Read-modify-write of the channel's entry. A channel whose valid bit is clear
    // still holds the values from an earlier frame and reads as the cleared entry.
    always_comb begin
        if (r_fwd_hit) begin
            old_entry = r_fwd_data;
        end else if (r_entry_valid[r_s1_ch]) begin
            old_entry = mfls_pkg::t_entry'(rd_data);
        end else begin
            old_entry = mfls_pkg::RESET_ENTRY;
        end
        magnitude = r_s1_sample[15] ? ({1'b0, ~r_s1_sample} + 17'd1) : {1'b0, r_s1_sample};
        new_entry.minimum = (r_s1_sample < old_entry.minimum) ? r_s1_sample : old_entry.minimum;
        new_entry.maximum = (r_s1_sample > old_entry.maximum) ? r_s1_sample : old_entry.maximum;
        new_entry.sum     = old_entry.sum + mfls_pkg::SUM_W'(magnitude);
    end

    assign emit_entry = r_entry_valid[r_emit_ch] ? mfls_pkg::t_entry'(rd_data)
                                                 : mfls_pkg::RESET_ENTRY;

    always_comb begin
        n_ch_pos  = r_ch_pos;
        n_smp_pos = r_smp_pos;
        if (accept) begin
            if (r_ch_pos == mfls_pkg::LAST_CH) begin
                n_ch_pos  = '0;
                n_smp_pos = (r_smp_pos == mfls_pkg::LAST_SMP) ? '0 : r_smp_pos + 1'b1;
            end else begin
                n_ch_pos = r_ch_pos + 1'b1;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_emit_ch     = r_emit_ch;
        n_entry_valid = r_entry_valid;
        rd_en         = 1'b0;
        rd_addr       = r_ch_pos;
        load_out      = 1'b0;
        if (wr_en) begin
            n_entry_valid[r_s1_ch] = 1'b1;
        end
        unique case (r_state)
            mfls_pkg::ST_ACC: begin
                rd_en     = accept;
                n_emit_ch = '0;
                if (r_s1_valid && r_s1_frame_end) begin
                    n_state = mfls_pkg::ST_READ;
                end
            end
            mfls_pkg::ST_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_emit_ch;
                n_state = mfls_pkg::ST_LOAD;
            end
            mfls_pkg::ST_LOAD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_emit_ch == mfls_pkg::LAST_CH) begin
                        n_state       = mfls_pkg::ST_ACC;
                        n_entry_valid = '0;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = r_emit_ch + 1'b1;
                        n_emit_ch = r_emit_ch + 1'b1;
                    end
                end
            end
            default: begin
                n_state = mfls_pkg::ST_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mfls_pkg::ST_ACC;
            r_ch_pos      <= '0;
            r_smp_pos     <= '0;
            r_emit_ch     <= '0;
            r_entry_valid <= '0;
            r_s1_valid    <= 1'b0;
            r_fwd_hit     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_ch_pos      <= n_ch_pos;
            r_smp_pos     <= n_smp_pos;
            r_emit_ch     <= n_emit_ch;
            r_entry_valid <= n_entry_valid;
            r_s1_valid    <= accept;
            // With a single channel the next item reads the entry being written.
            r_fwd_hit     <= wr_en && rd_en && (rd_addr == r_s1_ch);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= new_entry;
        if (accept) begin
            r_s1_sample    <= i_sample;
            r_s1_ch        <= r_ch_pos;
            r_s1_frame_end <= (r_ch_pos == mfls_pkg::LAST_CH)
                              && (r_smp_pos == mfls_pkg::LAST_SMP);
        end
        if (load_out) begin
            r_out_channel <= 3'(r_emit_ch);
            r_out_minimum <= emit_entry.minimum;
            r_out_maximum <= emit_entry.maximum;
            r_out_mean    <= 16'(emit_entry.sum >> mfls_pkg::SMP_LOG2);
            r_out_last    <= (r_emit_ch == mfls_pkg::LAST_CH);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_channel        = r_out_channel;
    assign o_minimum        = r_out_minimum;
    assign o_maximum        = r_out_maximum;
    assign o_mean_magnitude = r_out_mean;
    assign o_last           = r_out_last;

endmodule

[hw/rtl/mfls_checker.sv]
// Port-level checks for the frame statistics core, bound to its top level.
// Depends on mfls_pkg and sees the core's ports only.
`timescale 1ns / 1ps

module mfls_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic [2:0]         o_channel,
    input logic signed [15:0] o_minimum,
    input logic signed [15:0] o_maximum,
    input logic [15:0]        o_mean_magnitude,
    input logic               o_last,
    input logic               i_stall
);

    // A result held back by the receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_channel) && $stable(o_minimum)
                               && $stable(o_maximum) && $stable(o_mean_magnitude)
                               && $stable(o_last))
        else $error("stalled result changed");

    // Every channel sees at least one sample per frame, so its range is never inverted.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_minimum <= o_maximum) && (o_mean_magnitude <= 16'h8000))
        else $error("result range inconsistent");

    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_channel == mfls_pkg::LAST_CH_FIELD)
        else $error("last flag on wrong channel");

    // Input stays stalled until the frame's last result is loaded into the output.
    a_emit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("item accepted during result read-out");

endmodule

bind multichannel_frame_level_stats_core mfls_checker u_mfls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .o_channel       (o_channel),
    .o_minimum       (o_minimum),
    .o_maximum       (o_maximum),
    .o_mean_magnitude(o_mean_magnitude),
    .o_last          (o_last),
    .i_stall         (i_stall)
);

[tb/tb_multichannel_frame_level_stats_core.sv]
// Self-checking testbench for the per-channel frame statistics core.
// Drives whole frames of interleaved samples and checks every per-channel result against
// an in-bench predictor. Depends on mfls_pkg and multichannel_frame_level_stats_core.
`timescale 1ns / 1ps

module tb_multichannel_frame_level_stats_core;

    localparam int FRAME_ITEMS   = mfls_pkg::CHANNELS * mfls_pkg::SAMPLES;
    localparam int RANDOM_FRAMES = 5;
    localparam int LONG_HOLD     = 400;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [15:0] S_MAX = mfls_pkg::SAMPLE_MAX;
    localparam logic signed [15:0] S_MIN = mfls_pkg::SAMPLE_MIN;

    typedef enum logic [1:0] {
        PAT_CONST,
        PAT_ALTERNATE,
        PAT_RAMP,
        PAT_STAIR
    } t_pattern;

    typedef struct packed {
        t_pattern           pattern;
        logic signed [15:0] value;
        logic               literal;
        logic signed [15:0] lit_min;
        logic signed [15:0] lit_max;
        logic [15:0]        lit_mean;
        logic               hold_at_end;
        logic               drain_after;
    } t_frame_row;

    typedef struct packed {
        logic [2:0]         channel;
        logic signed [15:0] minimum;
        logic signed [15:0] maximum;
        logic [15:0]        mean_magnitude;
        logic               last;
    } t_channel_stats;

    // Each row is one whole frame; the literal columns hold for every channel of it.
    t_frame_row frame_plan [7] = '{
        '{PAT_CONST, 16'sd0, 1'b1, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b0},
        '{PAT_CONST, S_MAX, 1'b1, S_MAX, S_MAX, 16'd32767, 1'b0, 1'b0},
        '{PAT_CONST, S_MIN, 1'b1, S_MIN, S_MIN, 16'd32768, 1'b0, 1'b1},
        '{PAT_CONST, -16'sd1, 1'b1, -16'sd1, -16'sd1, 16'd1, 1'b0, 1'b0},
        '{PAT_ALTERNATE, 16'sd0, 1'b1, S_MIN, S_MAX, 16'd32767, 1'b1, 1'b0},
        '{PAT_RAMP, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b0},
        '{PAT_STAIR, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b0}
    };

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               i_valid  = 1'b0;
    logic signed [15:0] i_sample = '0;
    logic               i_stall  = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [2:0]         o_channel;
    logic signed [15:0] o_minimum;
    logic signed [15:0] o_maximum;
    logic [15:0]        o_mean_magnitude;
    logic               o_last;

    t_channel_stats frame_results_q [$];

    int signed   acc_min [mfls_pkg::CHANNELS];
    int signed   acc_max [mfls_pkg::CHANNELS];
    int unsigned acc_sum [mfls_pkg::CHANNELS];
    int unsigned next_channel;
    int unsigned samples_done;

    logic               literal_on;
    logic signed [15:0] literal_min;
    logic signed [15:0] literal_max;
    logic [15:0]        literal_mean;

    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    logic hold_req        = 1'b0;
    logic hold_taken      = 1'b0;
    int   hold_left       = 0;
    int   fail_count      = 0;

    multichannel_frame_level_stats_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_sample         (i_sample),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .o_channel        (o_channel),
        .o_minimum        (o_minimum),
        .o_maximum        (o_maximum),
        .o_mean_magnitude (o_mean_magnitude),
        .o_last           (o_last),
        .i_stall          (i_stall)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_accumulators();
        for (int c = 0; c < mfls_pkg::CHANNELS; c++) begin
            acc_min[c] = 32767;
            acc_max[c] = -32768;
            acc_sum[c] = 0;
        end
        next_channel = 0;
        samples_done = 0;
    endfunction

    // Folds one accepted sample into the running statistics and, on the last sample
    // of a frame, queues one expected result per channel.
    function automatic void accumulate_sample(logic signed [15:0] value);
        int             v;
        t_channel_stats r;
        v = value;
        if (v < acc_min[next_channel]) acc_min[next_channel] = v;
        if (v > acc_max[next_channel]) acc_max[next_channel] = v;
        acc_sum[next_channel] += (v < 0) ? -v : v;
        next_channel++;
        if (next_channel < mfls_pkg::CHANNELS) return;
        next_channel = 0;
        samples_done++;
        if (samples_done < mfls_pkg::SAMPLES) return;
        for (int c = 0; c < mfls_pkg::CHANNELS; c++) begin
            r.channel        = 3'(c);
            r.minimum        = literal_on ? literal_min : 16'(acc_min[c]);
            r.maximum        = literal_on ? literal_max : 16'(acc_max[c]);
            r.mean_magnitude = literal_on ? literal_mean
                                          : 16'(acc_sum[c] / mfls_pkg::SAMPLES);
            r.last           = (c == mfls_pkg::CHANNELS - 1);
            frame_results_q.push_back(r);
        end
        clear_accumulators();
    endfunction

    function automatic logic signed [15:0] random_sample(int flavour, int span);
        int pick;
        int r;
        pick = $urandom_range(19);
        if (pick == 0) return S_MIN;
        if (pick == 1) return S_MAX;
        case (flavour)
            0: return 16'($urandom);
            1: begin
                r = $urandom_range(2 * (1 << span));
                return 16'(r - (1 << span));
            end
            default: return 16'($urandom_range(32767));
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic push_sample(input logic signed [15:0] value);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accumulate_sample(value);
    endtask

    task automatic send_planned_frame(input t_frame_row row);
        logic signed [15:0] v;
        literal_on   = row.literal;
        literal_min  = row.lit_min;
        literal_max  = row.lit_max;
        literal_mean = row.lit_mean;
        for (int s = 0; s < mfls_pkg::SAMPLES; s++) begin
            for (int c = 0; c < mfls_pkg::CHANNELS; c++) begin
                case (row.pattern)
                    PAT_CONST:     v = row.value;
                    PAT_ALTERNATE: v = s[0] ? S_MIN : S_MAX;
                    PAT_RAMP:      v = 16'(c * 4111 + s * 263 - 20000);
                    default:       v = 16'(c * 8191 - 32768);
                endcase
                // Hold the output back across the frame end so the input side backs up.
                if (row.hold_at_end && s == mfls_pkg::SAMPLES - 1
                        && c == mfls_pkg::CHANNELS - 1) begin
                    hold_req <= 1'b1;
                end
                push_sample(v);
            end
        end
        literal_on = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (frame_results_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            i_stall    <= 1'b1;
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_channel_stats want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (frame_results_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected result: ch %0d min %0d max %0d mean %0d last %0b",
                             o_channel, o_minimum, o_maximum, o_mean_magnitude, o_last);
                end
            end else begin
                want = frame_results_q.pop_front();
                if (o_channel !== want.channel || o_minimum !== want.minimum
                        || o_maximum !== want.maximum
                        || o_mean_magnitude !== want.mean_magnitude
                        || o_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch: want ch %0d min %0d max %0d mean %0d last %0b",
                                 want.channel, want.minimum, want.maximum,
                                 want.mean_magnitude, want.last);
                        $display("          got  ch %0d min %0d max %0d mean %0d last %0b",
                                 o_channel, o_minimum, o_maximum, o_mean_magnitude, o_last);
                    end
                end
            end
        end
    end

    initial begin
        int flavour;
        int span;
        clear_accumulators();
        literal_on = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frame_plan[i]) begin
            send_planned_frame(frame_plan[i]);
            if (frame_plan[i].drain_after) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                wait_for_drain();
            end
        end

        for (int f = 0; f < RANDOM_FRAMES; f++) begin
            case (f % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin sender_idle_pct = 67; recv_stall_pct <= 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct <= 67; end
                default: begin sender_idle_pct = 33; recv_stall_pct <= 33; end
            endcase
            flavour = $urandom_range(2);
            span    = $urandom_range(14);
            for (int n = 0; n < FRAME_ITEMS; n++) begin
                push_sample(random_sample(flavour, span));
            end
        end

        i_valid <= 1'b0;
        wait_for_drain();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && frame_results_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
